/* hdl/scfe_pkg.sv */
`default_nettype none

package scfe_pkg;

    localparam int unsigned SCFE_QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_FEEDBACK = 2'd0;
    localparam logic [1:0] OP_COMMAND  = 2'd1;
    localparam logic [1:0] OP_STOP     = 2'd2;

    localparam logic [2:0] KIND_NONE     = 3'd0;
    localparam logic [2:0] KIND_FRAME    = 3'd1;
    localparam logic [2:0] KIND_FEEDBACK = 3'd2;
    localparam logic [2:0] KIND_RANGE    = 3'd3;
    localparam logic [2:0] KIND_SHUTDOWN = 3'd4;

    localparam logic [2:0] MODE_CURRENT   = 3'd1;
    localparam logic [2:0] MODE_SPEED     = 3'd2;
    localparam logic [2:0] MODE_POSITION  = 3'd3;
    localparam logic [2:0] MODE_POS_SPEED = 3'd4;

    localparam logic [3:0] CODE_CURRENT   = 4'd1;
    localparam logic [3:0] CODE_SPEED     = 4'd3;
    localparam logic [3:0] CODE_POSITION  = 4'd4;
    localparam logic [3:0] CODE_POS_SPEED = 4'd6;

    localparam logic [31:0] CURRENT_LIMIT   = 32'd60000;
    localparam logic [31:0] SPEED_LIMIT_MAX = 32'd100000;
    localparam logic [31:0] POSITION_LIMIT  = 32'd360000000;
    localparam logic signed [10:0] POSITION_SCALE = 11'sd1000;

    localparam logic [3:0] LEN_SHORT = 4'd4;
    localparam logic [3:0] LEN_LONG  = 4'd8;

    localparam logic [2:0] REG_NODE_ID          = 3'd0;
    localparam logic [2:0] REG_LOOP_MODE        = 3'd1;
    localparam logic [2:0] REG_GRASP_ENABLE     = 3'd2;
    localparam logic [2:0] REG_TORQUE_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_SPEED_LIMIT      = 3'd4;
    localparam logic [2:0] REG_ACCEL_LIMIT      = 3'd5;
    localparam logic [2:0] REG_LISTEN_ONLY      = 3'd6;

    typedef struct packed {
        logic [7:0]  node_id;
        logic [2:0]  loop_mode;
        logic        grasp_enable;
        logic [14:0] torque_threshold;
        logic [14:0] speed_limit;
        logic [14:0] accel_limit;
        logic        listen_only;
    } scfe_cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  code;
        logic        use_held;
        logic [31:0] cmd_word;
        logic [15:0] held;
        logic        grasp_held;
        logic [7:0]  fault_code;
        logic [15:0] position_raw;
        logic [15:0] velocity_raw;
        logic [15:0] current_raw;
        logic [7:0]  temperature;
    } scfe_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [11:0] out_id;
        logic [3:0]  out_len;
        logic [63:0] out_bytes;
        logic        grasp_held;
        logic [7:0]  fault_code;
        logic [15:0] position_raw;
        logic [15:0] velocity_raw;
        logic [15:0] current_raw;
        logic [7:0]  temperature;
    } scfe_result_t;

endpackage

`default_nettype wire

/* hdl/scfe_front.sv */
`default_nettype none

module scfe_front
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire scfe_pkg::scfe_cfg_t cfg,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          in_op,
    input  wire logic [28:0]         frame_id,
    input  wire logic [63:0]         frame_bytes,
    input  wire logic [31:0]         command_value,
    input  wire logic                command_present,
    input  wire logic                queue_ready,
    output logic                     push,
    output scfe_pkg::scfe_item_t     item
);
    import scfe_pkg::*;

    logic        grasp_reg;
    logic        grasp_next;
    logic [15:0] held_reg;
    logic [15:0] held_next;
    logic        accept;
    logic [15:0] pos;
    logic [15:0] vel;
    logic [15:0] cur;
    logic [16:0] mag;
    logic [20:0] mag10;
    logic [18:0] thr9;
    logic [31:0] cmd_mag;
    logic [31:0] lim;
    logic [3:0]  code;
    logic        is_pos;
    logic        hold;
    scfe_item_t  item_next;

    assign in_ready = queue_ready;
    assign accept   = in_valid && queue_ready;
    assign push     = accept;
    assign item     = item_next;

    assign pos     = frame_bytes[63:48];
    assign vel     = frame_bytes[47:32];
    assign cur     = frame_bytes[31:16];
    assign mag     = cur[15] ? (17'h10000 - {1'b0, cur}) : {1'b0, cur};
    assign mag10   = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0};
    assign thr9    = {1'b0, cfg.torque_threshold, 3'b000} + {4'b0000, cfg.torque_threshold};
    assign cmd_mag = command_value[31] ? (32'd0 - command_value) : command_value;
    assign is_pos  = (cfg.loop_mode == MODE_POSITION) || (cfg.loop_mode == MODE_POS_SPEED);
    assign hold    = cfg.grasp_enable && grasp_reg;

    always_comb
    begin
        unique case (cfg.loop_mode)
            MODE_CURRENT:
            begin
                code = CODE_CURRENT;
                lim  = CURRENT_LIMIT;
            end
            MODE_SPEED:
            begin
                code = CODE_SPEED;
                lim  = SPEED_LIMIT_MAX;
            end
            MODE_POSITION:
            begin
                code = CODE_POSITION;
                lim  = POSITION_LIMIT;
            end
            MODE_POS_SPEED:
            begin
                code = CODE_POS_SPEED;
                lim  = POSITION_LIMIT;
            end
            default:
            begin
                code = CODE_CURRENT;
                lim  = CURRENT_LIMIT;
            end
        endcase
    end

    always_comb
    begin
        item_next  = '0;
        grasp_next = grasp_reg;
        held_next  = held_reg;
        item_next.held = held_reg;
        unique case (in_op)
            OP_FEEDBACK:
            begin
                if (frame_id == {21'd0, cfg.node_id})
                begin
                    item_next.kind = KIND_FEEDBACK;
                    if (cfg.grasp_enable && (cfg.torque_threshold != 15'd0))
                    begin
                        if (mag >= {2'b00, cfg.torque_threshold})
                        begin
                            if (!grasp_reg)
                            begin
                                grasp_next = 1'b1;
                                held_next  = pos;
                            end
                        end
                        else if (grasp_reg && (mag10 < {2'b00, thr9}))
                        begin
                            grasp_next = 1'b0;
                            held_next  = 16'd0;
                        end
                    end
                    else if ((cfg.torque_threshold != 15'd0) &&
                             (mag > {2'b00, cfg.torque_threshold}))
                    begin
                        item_next.kind = KIND_SHUTDOWN;
                    end
                    item_next.fault_code   = frame_bytes[7:0];
                    item_next.position_raw = pos;
                    item_next.velocity_raw = vel;
                    item_next.current_raw  = cur;
                    item_next.temperature  = frame_bytes[15:8];
                end
            end
            OP_COMMAND:
            begin
                if (!cfg.listen_only && command_present &&
                    (cfg.loop_mode >= MODE_CURRENT) && (cfg.loop_mode <= MODE_POS_SPEED))
                begin
                    item_next.code = code;
                    if (hold && !is_pos)
                    begin
                        item_next.kind     = KIND_FRAME;
                        item_next.cmd_word = 32'd0;
                    end
                    else if (hold)
                    begin
                        item_next.kind     = KIND_FRAME;
                        item_next.use_held = 1'b1;
                    end
                    else if (cmd_mag >= lim)
                    begin
                        item_next.kind = KIND_RANGE;
                    end
                    else
                    begin
                        item_next.kind     = KIND_FRAME;
                        item_next.cmd_word = command_value;
                    end
                end
            end
            OP_STOP:
            begin
                grasp_next = 1'b0;
                held_next  = 16'd0;
            end
            default:
            begin
                grasp_next = grasp_reg;
            end
        endcase
        item_next.grasp_held = grasp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grasp_reg <= 1'b0;
            held_reg  <= 16'd0;
        end
        else if (accept)
        begin
            grasp_reg <= grasp_next;
            held_reg  <= held_next;
        end
    end

    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_op == OP_STOP)) |=> !grasp_reg)
        else $error("grasp still held after stop");

    a_held_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !grasp_reg |-> (held_reg == 16'd0))
        else $error("held position kept without grasp");

endmodule

`default_nettype wire

/* hdl/scfe_queue.sv */
`default_nettype none

module scfe_queue
#(
    parameter int unsigned DEPTH = scfe_pkg::SCFE_QUEUE_DEPTH
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire scfe_pkg::scfe_item_t push_item,
    output logic                      ready,
    input  wire logic                 pop,
    output logic                      valid,
    output scfe_pkg::scfe_item_t      head_item
);
    import scfe_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    scfe_item_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    assign ready     = cnt_reg != CNT_W'(DEPTH);
    assign valid     = cnt_reg != '0;
    assign do_push   = push && ready;
    assign do_pop    = pop && valid;
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue fill beyond depth");

    a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (cnt_reg == CNT_W'($past(cnt_reg) + 1'b1)))
        else $error("queue fill not advanced on push");

endmodule

`default_nettype wire

/* hdl/scfe_back.sv */
`default_nettype none

module scfe_back
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire scfe_pkg::scfe_cfg_t  cfg,
    input  wire logic                 q_valid,
    output logic                      q_pop,
    input  wire scfe_pkg::scfe_item_t q_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output scfe_pkg::scfe_result_t    out_result
);
    import scfe_pkg::*;

    logic                out_valid_reg;
    scfe_result_t        result_reg;
    scfe_result_t        result_next;
    logic signed [26:0]  held_scaled;
    logic [31:0]         word;

    assign q_pop      = q_valid && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    assign held_scaled = $signed(q_item.held) * POSITION_SCALE;
    assign word        = q_item.use_held ? {{5{held_scaled[26]}}, held_scaled} : q_item.cmd_word;

    always_comb
    begin
        result_next              = '0;
        result_next.kind         = q_item.kind;
        result_next.grasp_held   = q_item.grasp_held;
        result_next.fault_code   = q_item.fault_code;
        result_next.position_raw = q_item.position_raw;
        result_next.velocity_raw = q_item.velocity_raw;
        result_next.current_raw  = q_item.current_raw;
        result_next.temperature  = q_item.temperature;
        priority if (q_item.kind == KIND_FRAME)
        begin
            result_next.out_id = {q_item.code, cfg.node_id};
            if (q_item.code == CODE_POS_SPEED)
            begin
                result_next.out_len   = LEN_LONG;
                result_next.out_bytes = {word, 1'b0, cfg.speed_limit, 1'b0, cfg.accel_limit};
            end
            else
            begin
                result_next.out_len   = LEN_SHORT;
                result_next.out_bytes = {word, 32'd0};
            end
        end
        else if (q_item.kind == KIND_SHUTDOWN)
        begin
            result_next.out_id  = {CODE_CURRENT, cfg.node_id};
            result_next.out_len = LEN_SHORT;
        end
        else
        begin
            result_next.out_id = 12'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> out_valid_reg)
        else $error("output register empty after pop");

endmodule

`default_nettype wire

/* hdl/servo_can_frame_engine_unit.sv */
// Accepted s_ items are written into the queue, then popped into the m_ output register.
// Throughput: one item per cycle while m_tready is high; the two-entry queue and
// the output register let s_tready stay high while m_ stalls for one item.
// Reset (rst_n low, asynchronous): clears the configuration registers, grasp flag
// and held position, empties the queue and drops m_tvalid.
`default_nettype none

module servo_can_frame_engine_unit
#(
    parameter int unsigned QUEUE_DEPTH = scfe_pkg::SCFE_QUEUE_DEPTH
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // frame_id[28:0], frame_bytes[92:29], command_value[124:93],
    // command_present[125], zero fill
    input  wire logic [127:0] s_tdata,
    // op[1:0]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_id[11:0], out_len[15:12], out_bytes[79:16], grasp_held[80],
    // fault_code[88:81], position_raw[104:89], velocity_raw[120:105],
    // current_raw[136:121], temperature[144:137], zero fill
    output logic [151:0]      m_tdata,
    // kind[2:0]
    output logic [2:0]        m_tuser
);
    import scfe_pkg::*;

    scfe_cfg_t    cfg_reg;
    logic         cfg_wr;
    logic         push;
    logic         queue_ready;
    logic         q_valid;
    logic         q_pop;
    scfe_item_t   push_item;
    scfe_item_t   head_item;
    scfe_result_t result;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_NODE_ID:          cfg_reg.node_id          <= pwdata[7:0];
                REG_LOOP_MODE:        cfg_reg.loop_mode        <= pwdata[2:0];
                REG_GRASP_ENABLE:     cfg_reg.grasp_enable     <= pwdata[0];
                REG_TORQUE_THRESHOLD: cfg_reg.torque_threshold <= pwdata[14:0];
                REG_SPEED_LIMIT:      cfg_reg.speed_limit      <= pwdata[14:0];
                REG_ACCEL_LIMIT:      cfg_reg.accel_limit      <= pwdata[14:0];
                REG_LISTEN_ONLY:      cfg_reg.listen_only      <= pwdata[0];
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_NODE_ID:          prdata = {24'd0, cfg_reg.node_id};
            REG_LOOP_MODE:        prdata = {29'd0, cfg_reg.loop_mode};
            REG_GRASP_ENABLE:     prdata = {31'd0, cfg_reg.grasp_enable};
            REG_TORQUE_THRESHOLD: prdata = {17'd0, cfg_reg.torque_threshold};
            REG_SPEED_LIMIT:      prdata = {17'd0, cfg_reg.speed_limit};
            REG_ACCEL_LIMIT:      prdata = {17'd0, cfg_reg.accel_limit};
            REG_LISTEN_ONLY:      prdata = {31'd0, cfg_reg.listen_only};
            default:              prdata = 32'd0;
        endcase
    end

    scfe_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_op           (s_tuser),
        .frame_id        (s_tdata[28:0]),
        .frame_bytes     (s_tdata[92:29]),
        .command_value   (s_tdata[124:93]),
        .command_present (s_tdata[125]),
        .queue_ready     (queue_ready),
        .push            (push),
        .item            (push_item)
    );

    scfe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .ready     (queue_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .head_item (head_item)
    );

    scfe_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_item     (head_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tuser = result.kind;
    assign m_tdata = {7'd0, result.temperature, result.current_raw, result.velocity_raw,
                      result.position_raw, result.fault_code, result.grasp_held,
                      result.out_bytes, result.out_len, result.out_id};

endmodule

`default_nettype wire

/* tb/servo_frame_checker.sv */
`timescale 1ns / 100ps

module servo_frame_checker
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    input  wire logic         pready,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [127:0] s_tdata,
    input  wire logic [1:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [151:0] m_tdata,
    input  wire logic [2:0]   m_tuser,
    output int                fail_count,
    output int                open_frames,
    output int                frames_checked,
    output int                grasp_sets,
    output int                trips
);

    import scfe_pkg::*;

    scfe_cfg_t          joint_cfg;
    logic               grasp_flag;
    logic signed [15:0] held_pos;
    scfe_result_t       expected_frames[$];
    scfe_result_t       want;

    function automatic scfe_result_t predict_frame(
        input logic [1:0]         op,
        input logic [28:0]        fid,
        input logic [63:0]        fb,
        input logic signed [31:0] cmd,
        input logic               present
    );
        scfe_result_t       r;
        logic signed [15:0] pos;
        logic signed [15:0] vel;
        logic signed [15:0] cur;
        int                 mag;
        int                 thr;
        longint             v;
        longint             lim;
        logic [3:0]         code;
        logic               hold;
        r = '0;
        pos = fb[63:48];
        vel = fb[47:32];
        cur = fb[31:16];
        case (op)
            OP_FEEDBACK:
            begin
                if (fid == {21'd0, joint_cfg.node_id})
                begin
                    mag = cur;
                    if (mag < 0)
                        mag = -mag;
                    thr = int'(joint_cfg.torque_threshold);
                    r.kind = KIND_FEEDBACK;
                    if (joint_cfg.grasp_enable && thr > 0)
                    begin
                        if (mag >= thr)
                        begin
                            if (!grasp_flag)
                            begin
                                grasp_flag = 1'b1;
                                held_pos = pos;
                                grasp_sets++;
                            end
                        end
                        else if (grasp_flag && mag * 10 < thr * 9)
                        begin
                            grasp_flag = 1'b0;
                            held_pos = '0;
                        end
                    end
                    else if (thr != 0 && mag > thr)
                    begin
                        r.kind = KIND_SHUTDOWN;
                        r.out_id = {CODE_CURRENT, joint_cfg.node_id};
                        r.out_len = LEN_SHORT;
                        trips++;
                    end
                    r.fault_code = fb[7:0];
                    r.position_raw = pos;
                    r.velocity_raw = vel;
                    r.current_raw = cur;
                    r.temperature = fb[15:8];
                end
            end
            OP_COMMAND:
            begin
                if (!joint_cfg.listen_only && present &&
                    joint_cfg.loop_mode >= MODE_CURRENT && joint_cfg.loop_mode <= MODE_POS_SPEED)
                begin
                    hold = joint_cfg.grasp_enable && grasp_flag;
                    v = cmd;
                    case (joint_cfg.loop_mode)
                        MODE_CURRENT:
                        begin
                            code = CODE_CURRENT;
                            lim = CURRENT_LIMIT;
                            if (hold)
                                v = 0;
                        end
                        MODE_SPEED:
                        begin
                            code = CODE_SPEED;
                            lim = SPEED_LIMIT_MAX;
                            if (hold)
                                v = 0;
                        end
                        default:
                        begin
                            code = (joint_cfg.loop_mode == MODE_POSITION) ? CODE_POSITION
                                                                          : CODE_POS_SPEED;
                            lim = POSITION_LIMIT;
                            if (hold)
                            begin
                                v = held_pos;
                                v = v * POSITION_SCALE;
                            end
                        end
                    endcase
                    if ((v < 0 ? -v : v) >= lim)
                        r.kind = KIND_RANGE;
                    else
                    begin
                        r.kind = KIND_FRAME;
                        r.out_id = {code, joint_cfg.node_id};
                        if (code == CODE_POS_SPEED)
                        begin
                            r.out_len = LEN_LONG;
                            r.out_bytes = {v[31:0], 1'b0, joint_cfg.speed_limit,
                                           1'b0, joint_cfg.accel_limit};
                        end
                        else
                        begin
                            r.out_len = LEN_SHORT;
                            r.out_bytes = {v[31:0], 32'd0};
                        end
                    end
                end
            end
            OP_STOP:
            begin
                grasp_flag = 1'b0;
                held_pos = '0;
            end
            default: ;
        endcase
        r.grasp_held = grasp_flag;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            joint_cfg = '0;
            grasp_flag = 1'b0;
            held_pos = '0;
            expected_frames.delete();
            fail_count = 0;
            open_frames = 0;
            frames_checked = 0;
            grasp_sets = 0;
            trips = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_NODE_ID:          joint_cfg.node_id = pwdata[7:0];
                    REG_LOOP_MODE:        joint_cfg.loop_mode = pwdata[2:0];
                    REG_GRASP_ENABLE:     joint_cfg.grasp_enable = pwdata[0];
                    REG_TORQUE_THRESHOLD: joint_cfg.torque_threshold = pwdata[14:0];
                    REG_SPEED_LIMIT:      joint_cfg.speed_limit = pwdata[14:0];
                    REG_ACCEL_LIMIT:      joint_cfg.accel_limit = pwdata[14:0];
                    REG_LISTEN_ONLY:      joint_cfg.listen_only = pwdata[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                frames_checked++;
                if (expected_frames.size() == 0)
                begin
                    $error("result with no prediction waiting, kind %0d", m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    compare_field("kind", 64'(want.kind), 64'(m_tuser));
                    compare_field("out_id", 64'(want.out_id), 64'(m_tdata[11:0]));
                    compare_field("out_len", 64'(want.out_len), 64'(m_tdata[15:12]));
                    compare_field("out_bytes", want.out_bytes, m_tdata[79:16]);
                    compare_field("grasp_held", 64'(want.grasp_held), 64'(m_tdata[80]));
                    compare_field("fault_code", 64'(want.fault_code), 64'(m_tdata[88:81]));
                    compare_field("position_raw", 64'(want.position_raw),
                                  64'(m_tdata[104:89]));
                    compare_field("velocity_raw", 64'(want.velocity_raw),
                                  64'(m_tdata[120:105]));
                    compare_field("current_raw", 64'(want.current_raw),
                                  64'(m_tdata[136:121]));
                    compare_field("temperature", 64'(want.temperature),
                                  64'(m_tdata[144:137]));
                end
            end
            if (s_tvalid && s_tready)
                expected_frames.insert(expected_frames.size(),
                                       predict_frame(s_tuser, s_tdata[28:0], s_tdata[92:29],
                                                     s_tdata[124:93], s_tdata[125]));
            open_frames = expected_frames.size();
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    import scfe_pkg::*;

    localparam logic [1:0] OP_SPARE   = 2'd3;
    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_SPARE = 3'd7;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [4:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;
    logic           s_tvalid;
    logic           s_tready;
    logic [127:0]   s_tdata;
    logic [1:0]     s_tuser;
    logic           m_tvalid;
    logic           m_tready;
    logic [151:0]   m_tdata;
    logic [2:0]     m_tuser;

    int             fail_count;
    int             open_frames;
    int             frames_checked;
    int             grasp_sets;
    int             trips;

    logic           tx_idle;
    logic           rx_idle;
    logic [7:0]     cur_node;
    logic [2:0]     cur_mode;
    int             cur_thr;
    int             sent;
    int             settings;

    servo_can_frame_engine_unit u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    servo_frame_checker u_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .fail_count     (fail_count),
        .open_frames    (open_frames),
        .frames_checked (frames_checked),
        .grasp_sets     (grasp_sets),
        .trips          (trips)
    );

    always
    begin
        #4;
        clk = 1'b1;
        #4;
        clk = 1'b0;
    end

    initial
    begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int unsigned stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = rx_idle ? $urandom_range(0, 13) : 0;
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(input logic [7:0] node, input logic [2:0] mode, input logic ge,
                             input logic [14:0] thr, input logic [14:0] spd,
                             input logic [14:0] acc, input logic lo);
        reg_write(REG_NODE_ID, {24'd0, node});
        reg_write(REG_LOOP_MODE, {29'd0, mode});
        reg_write(REG_GRASP_ENABLE, {31'd0, ge});
        reg_write(REG_TORQUE_THRESHOLD, {17'd0, thr});
        reg_write(REG_SPEED_LIMIT, {17'd0, spd});
        reg_write(REG_ACCEL_LIMIT, {17'd0, acc});
        reg_write(REG_LISTEN_ONLY, {31'd0, lo});
        cur_node = node;
        cur_mode = mode;
        cur_thr = int'(thr);
        settings++;
    endtask

    task automatic push_item(input logic [1:0] op, input logic [28:0] fid, input logic [63:0] fb,
                             input logic [31:0] val, input logic pres);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 13) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {2'b00, pres, val, fb, fid};
        do @(posedge clk); while (!s_tready);
        sent++;
    endtask

    // hold the sender until every prediction has been answered
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (open_frames == 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic random_settings();
        logic [7:0]  node;
        logic [2:0]  mode;
        logic [14:0] thr;
        logic [14:0] spd;
        logic [14:0] acc;
        case ($urandom_range(0, 3))
            0:       node = 8'h00;
            1:       node = 8'hFF;
            default: node = 8'($urandom);
        endcase
        mode = ($urandom_range(0, 9) == 0) ? MODE_NONE
                                           : 3'($urandom_range(MODE_CURRENT, MODE_POS_SPEED));
        case ($urandom_range(0, 5))
            0:       thr = 15'd0;
            1:       thr = 15'h7FFF;
            2:       thr = 15'd1;
            default: thr = 15'($urandom_range(50, 4000));
        endcase
        case ($urandom_range(0, 2))
            0:       spd = 15'd0;
            1:       spd = 15'd32766;
            default: spd = 15'($urandom_range(0, 32766));
        endcase
        case ($urandom_range(0, 2))
            0:       acc = 15'd0;
            1:       acc = 15'd32766;
            default: acc = 15'($urandom_range(0, 32766));
        endcase
        configure(node, mode, 1'($urandom_range(0, 1)), thr, spd, acc,
                  $urandom_range(0, 7) == 0);
    endtask

    task automatic random_item();
        int unsigned        r;
        int                 mag;
        logic [1:0]         op;
        logic [28:0]        fid;
        logic [15:0]        cur;
        logic [63:0]        fb;
        logic [31:0]        val;
        longint             lim;
        r = $urandom_range(0, 99);
        if (r < 46)
            op = OP_FEEDBACK;
        else if (r < 88)
            op = OP_COMMAND;
        else if (r < 97)
            op = OP_STOP;
        else
            op = OP_SPARE;
        r = $urandom_range(0, 9);
        if (r < 8)
            fid = {21'd0, cur_node};
        else if (r == 8)
            fid = {21'd0, cur_node} ^ (29'd1 << $urandom_range(0, 28));
        else
            fid = 29'($urandom);
        // steer the current around the trip and release points
        case ($urandom_range(0, 7))
            0:       mag = cur_thr;
            1:       mag = cur_thr + 1;
            2:       mag = cur_thr - 1;
            3:       mag = (9 * cur_thr + 9) / 10;
            4:       mag = (9 * cur_thr + 9) / 10 - 1;
            5:       mag = 32768;
            default: mag = int'($urandom_range(0, 32768));
        endcase
        if (mag < 0)
            mag = 0;
        if (mag > 32768)
            mag = 32768;
        cur = 16'(mag);
        if ($urandom_range(0, 1) == 1)
            cur = -cur;
        fb = {16'($urandom), 16'($urandom), cur, 16'($urandom)};
        if (cur_mode == MODE_CURRENT)
            lim = CURRENT_LIMIT;
        else if (cur_mode == MODE_SPEED)
            lim = SPEED_LIMIT_MAX;
        else
            lim = POSITION_LIMIT;
        case ($urandom_range(0, 11))
            0:       val = 32'(lim - 1);
            1:       val = 32'(1 - lim);
            2:       val = 32'(lim);
            3:       val = 32'(-lim);
            4:       val = $urandom;
            5:       val = 32'h8000_0000;
            6:       val = 32'h7FFF_FFFF;
            default: val = 32'(longint'($urandom_range(0, 32'(2 * lim - 2))) - lim + 1);
        endcase
        push_item(op, fid, fb, val, $urandom_range(0, 9) != 0);
    endtask

    initial
    begin
        int blk;
        int k;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_FEEDBACK;
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        cur_node = '0;
        cur_mode = MODE_NONE;
        cur_thr = 0;
        sent = 0;
        settings = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // safety shutdown, foreign frames and range limits in current mode
        configure(8'h2A, MODE_CURRENT, 1'b0, 15'd1000, 15'd100, 15'd200, 1'b0);
        push_item(OP_FEEDBACK, 29'h2A, {16'h7FFF, 16'h8000, 16'd1000, 8'hFF, 8'h00}, 32'd0, 1'b0);
        push_item(OP_FEEDBACK, 29'h2A, {16'h8000, 16'h7FFF, 16'(-1001), 8'h00, 8'h07},
                  32'd0, 1'b0);
        push_item(OP_FEEDBACK, 29'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_item(OP_FEEDBACK, 29'h2A, {16'h0000, 16'h0000, 16'h8000, 8'h55, 8'hAA},
                  32'd0, 1'b1);
        push_item(OP_COMMAND, 29'h0, 64'd0, 32'd59999, 1'b1);
        push_item(OP_COMMAND, 29'h0, 64'd0, 32'(-60000), 1'b1);
        push_item(OP_COMMAND, 29'h0, 64'd0, 32'd123, 1'b0);
        push_item(OP_SPARE, 29'h2A, 64'd0, 32'd7, 1'b1);
        push_item(OP_STOP, 29'h2A, 64'd0, 32'd0, 1'b1);
        drain();

        // grasp hysteresis and the held position in position-speed mode
        configure(8'h2A, MODE_POS_SPEED, 1'b1, 15'd2000, 15'd32766, 15'd0, 1'b0);
        push_item(OP_FEEDBACK, 29'h2A, {16'(-1234), 16'h0101, 16'd2000, 8'd40, 8'd0},
                  32'd0, 1'b0);
        push_item(OP_FEEDBACK, 29'h2A, {16'd77, 16'h0000, 16'(-1800), 8'd41, 8'd3},
                  32'd0, 1'b0);
        push_item(OP_COMMAND, 29'h0, 64'd0, 32'd42, 1'b1);
        push_item(OP_FEEDBACK, 29'h2A, {16'd78, 16'h0000, 16'd1799, 8'd42, 8'd0}, 32'd0, 1'b0);
        push_item(OP_COMMAND, 29'h0, 64'd0, 32'(-359999999), 1'b1);
        push_item(OP_COMMAND, 29'h0, 64'd0, 32'd360000000, 1'b1);
        push_item(OP_FEEDBACK, 29'h2A, {16'h7FFF, 16'h0000, 16'h7FFF, 8'd50, 8'd1},
                  32'd0, 1'b0);
        push_item(OP_COMMAND, 29'h0, 64'd0, 32'h7FFF_FFFF, 1'b1);
        push_item(OP_STOP, 29'h0, 64'd0, 32'd0, 1'b0);
        push_item(OP_COMMAND, 29'h0, 64'd0, 32'h8000_0000, 1'b1);
        drain();

        // listen only, no threshold, speed limits and an undefined mode
        configure(8'hFF, MODE_SPEED, 1'b0, 15'd0, 15'd0, 15'd32766, 1'b1);
        push_item(OP_COMMAND, 29'hFF, 64'd0, 32'd5, 1'b1);
        push_item(OP_FEEDBACK, 29'hFF, {16'h1234, 16'h8000, 16'h8000, 8'h00, 8'hFF},
                  32'd0, 1'b0);
        drain();
        configure(8'hFF, MODE_SPEED, 1'b0, 15'd0, 15'd0, 15'd32766, 1'b0);
        push_item(OP_COMMAND, 29'h0, 64'd0, 32'd99999, 1'b1);
        push_item(OP_COMMAND, 29'h0, 64'd0, 32'(-100000), 1'b1);
        drain();
        configure(8'h00, MODE_SPARE, 1'b1, 15'h7FFF, 15'd0, 15'd0, 1'b0);
        push_item(OP_COMMAND, 29'h0, 64'd0, 32'd1, 1'b1);

        for (blk = 0; blk < 31; blk++)
        begin
            drain();
            random_settings();
            {rx_idle, tx_idle} = 2'($urandom_range(0, 3));
            for (k = 0; k < 50; k++)
                random_item();
        end
        drain();

        $display("Covered %0d input transactions over %0d register settings, %0d results checked",
                 sent, settings, frames_checked);
        $display("Grasp latched %0d times, %0d safety disable frames predicted", grasp_sets, trips);
        if (fail_count == 0 && open_frames == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hdl/scfe_pkg.sv
hdl/scfe_front.sv
hdl/scfe_queue.sv
hdl/scfe_back.sv
hdl/servo_can_frame_engine_unit.sv
tb/servo_frame_checker.sv
tb/tb_top.sv
